FILE: design/haversine_central_angle_macros.svh
// assertion macros shared by the haversine central angle design
`ifndef HAVERSINE_CENTRAL_ANGLE_MACROS_SVH
`define HAVERSINE_CENTRAL_ANGLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HCA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hca implication check failed");

// next-cycle implication, checked out of reset
`define HCA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hca next-cycle check failed");

`endif

FILE: design/hca_pkg.sv
// types, constants and tables of the haversine central angle design
package hca_pkg;

	localparam int CORDIC_STEPS = 24;
	// front end, angle conversion, rotation cells, combine
	localparam int PRE_STAGES  = 1;
	localparam int CONV_STAGES = 4;
	localparam int COMB_STAGES = 4;
	localparam int LAT = PRE_STAGES + CONV_STAGES + CORDIC_STEPS + COMB_STAGES;
	localparam int NEG_DLY = CONV_STAGES + CORDIC_STEPS;

	localparam int LAT_W  = 28;
	localparam int LON_W  = 29;
	localparam int OUT_W  = 32;
	localparam int VEC_W  = 34;
	localparam int STEP_W = 5;

	localparam logic [29:0] HALF_TURN_Q21 = 30'd377487360;
	localparam logic [29:0] RIGHT_Q21     = 30'd188743680;
	localparam logic [29:0] HALF_TURN_Q20 = 30'd188743680;
	localparam logic [29:0] RIGHT_Q20     = 30'd94371840;

	localparam logic signed [VEC_W-1:0] GAIN_INV = 34'sd652032874;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// reciprocals of 45: a 29-bit value and a 17-bit value
	localparam logic [28:0] RECIP45_WIDE   = 29'd381774871;
	localparam int          RECIP45_WIDE_SH = 34;
	localparam logic [16:0] RECIP45_NARROW = 17'd93207;
	localparam int          RECIP45_NARROW_SH = 22;
	localparam logic [28:0] DIV_BY = 29'd45;
	localparam logic [15:0] ROUND_BIAS = 16'd22;

	localparam logic REG_QUERY_LAT = 1'b0;
	localparam logic REG_QUERY_LON = 1'b1;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} lane_t;

	function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] i);
		logic [31:0] t;
		t = 32'h0;
		case (i)
			5'd0:  t = 32'h20000000;
			5'd1:  t = 32'h12E4051E;
			5'd2:  t = 32'h09FB385B;
			5'd3:  t = 32'h051111D4;
			5'd4:  t = 32'h028B0D43;
			5'd5:  t = 32'h0145D7E1;
			5'd6:  t = 32'h00A2F61E;
			5'd7:  t = 32'h00517C55;
			5'd8:  t = 32'h0028BE53;
			5'd9:  t = 32'h00145F2F;
			5'd10: t = 32'h000A2F98;
			5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6;
			5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2FA;
			5'd15: t = 32'h0000517D;
			5'd16: t = 32'h000028BE;
			5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30;
			5'd19: t = 32'h00000518;
			5'd20: t = 32'h0000028C;
			5'd21: t = 32'h00000146;
			5'd22: t = 32'h000000A3;
			5'd23: t = 32'h00000051;
			5'd24: t = 32'h00000029;
			5'd25: t = 32'h00000014;
			5'd26: t = 32'h0000000A;
			5'd27: t = 32'h00000005;
			5'd28: t = 32'h00000003;
			5'd29: t = 32'h00000001;
			5'd30: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

endpackage

FILE: design/hca_if.sv
// point and result channel interfaces
interface hca_point_if;
	import hca_pkg::*;
	logic valid;
	logic ready;
	logic signed [LAT_W-1:0] point_lat;
	logic signed [LON_W-1:0] point_lon;
	modport source (output valid, output point_lat, output point_lon, input ready);
	modport sink (input valid, input point_lat, input point_lon, output ready);
endinterface

interface hca_result_if;
	import hca_pkg::*;
	logic valid;
	logic ready;
	logic [OUT_W-1:0] hav_angle;
	modport source (output valid, output hav_angle, input ready);
	modport sink (input valid, input hav_angle, output ready);
endinterface

FILE: design/haversine_central_angle.sv
// channel   | dir | payload
// point     | in  | point_lat (28 s), point_lon (29 s)
// result    | out | hav_angle (32 u)
// apb       | in  | query_lat at 0x0, query_lon at 0x4
//
// one point per cycle while the result is not stalled; the stages are the front end,
// the angle conversion, the cordic rotation cells, one cell per step, and the combine
// every stage moves together; a stalled result holds the whole chain and ready
// drops only while the result register is full and not taken
// arst_n clears the stage valid bits and the query registers
`include "haversine_central_angle_macros.svh"

module haversine_central_angle (
	input  logic                clk,
	input  logic                arst_n,
	hca_point_if.sink           point,
	hca_result_if.source        result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import hca_pkg::*;

	logic signed [LAT_W-1:0] query_lat_q;
	logic signed [LON_W-1:0] query_lon_q;
	logic                    reg_idx;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_lat_q <= '0;
			query_lon_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_QUERY_LAT: query_lat_q <= pwdata[LAT_W-1:0];
				REG_QUERY_LON: query_lon_q <= pwdata[LON_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_QUERY_LAT: prdata = 32'({1'b0, query_lat_q});
			REG_QUERY_LON: prdata = 32'({1'b0, query_lon_q});
			default:       prdata = '0;
		endcase
	end

	// pipeline advance
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en          = !vld_q[LAT-1] || result.ready;
	assign point.ready = en;
	assign result.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], point.valid};
	end

	// front end: differences, reduction to the first quadrant
	logic signed [28:0] dlat;
	logic signed [29:0] dlon;
	logic [29:0] alat, alon, alon_m, clat_a, clat_b;
	logic [27:0] hlat_a, hlon_a, cos_a_a, cos_b_a;
	logic        neg_a, neg_b;

	always_comb begin
		dlat = 29'(query_lat_q) - 29'(point.point_lat);
		dlon = 30'(query_lon_q) - 30'(point.point_lon);
		alat = dlat[28] ? 30'(-30'(dlat)) : 30'(dlat);
		alon = dlon[29] ? 30'(-dlon) : 30'(dlon);
		hlat_a = (alat > RIGHT_Q21) ? 28'(HALF_TURN_Q21 - alat) : alat[27:0];
		alon_m = (alon >= HALF_TURN_Q21) ? alon - HALF_TURN_Q21 : alon;
		hlon_a = (alon_m > RIGHT_Q21) ? 28'(HALF_TURN_Q21 - alon_m) : alon_m[27:0];
		clat_a = query_lat_q[LAT_W-1] ? 30'(-30'(query_lat_q)) : 30'(query_lat_q);
		clat_b = point.point_lat[LAT_W-1] ? 30'(-30'(point.point_lat)) : 30'(point.point_lat);
		neg_a  = clat_a > RIGHT_Q20;
		neg_b  = clat_b > RIGHT_Q20;
		cos_a_a = neg_a ? 28'(HALF_TURN_Q20 - clat_a) : clat_a[27:0];
		cos_b_a = neg_b ? 28'(HALF_TURN_Q20 - clat_b) : clat_b[27:0];
	end

	logic [27:0] ang_s1 [4];
	logic        neg_s1;
	logic        neg_dly_q [NEG_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1[0] <= hlat_a;
			ang_s1[1] <= hlon_a;
			ang_s1[2] <= cos_a_a;
			ang_s1[3] <= cos_b_a;
			neg_s1    <= neg_a ^ neg_b;
			neg_dly_q[0] <= neg_s1;
			for (int i = 1; i < NEG_DLY; i++)
				neg_dly_q[i] <= neg_dly_q[i-1];
		end
	end

	// lanes 0 and 1 are half angles, lanes 2 and 3 are latitudes for cosine
	lane_t chain [4][CORDIC_STEPS+1];

	for (genvar g = 0; g < 4; g++) begin : g_lane
		logic [30:0] bam;

		hca_bam u_bam (
			.clk   (clk),
			.en    (en),
			.q20   (g >= 2),
			.angle (ang_s1[g]),
			.bam   (bam)
		);

		assign chain[g][0].x = GAIN_INV;
		assign chain[g][0].y = '0;
		assign chain[g][0].z = VEC_W'(signed'({1'b0, bam}));

		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
			hca_cordic_cell u_cell (
				.clk      (clk),
				.en       (en),
				.step     (STEP_W'(k)),
				.lane_in  (chain[g][k]),
				.lane_out (chain[g][k+1])
			);
		end
	end

	hca_combine u_combine (
		.clk     (clk),
		.en      (en),
		.sin_lat (chain[0][CORDIC_STEPS].y),
		.sin_lon (chain[1][CORDIC_STEPS].y),
		.cos_a   (chain[2][CORDIC_STEPS].x),
		.cos_b   (chain[3][CORDIC_STEPS].x),
		.neg     (neg_dly_q[NEG_DLY-1]),
		.hav     (result.hav_angle)
	);

	`HCA_ASSERT_NXT(a_accept_enters, point.valid && point.ready, vld_q[0])
	`HCA_ASSERT_NXT(a_stall_holds, result.valid && !result.ready, $stable(vld_q))
	`HCA_ASSERT_IMP(a_out_from_chain, $rose(result.valid), $past(vld_q[LAT-2]))

endmodule

FILE: design/hca_bam.sv
// degrees to binary angle conversion, divide by 45 through reciprocals
module hca_bam (
	input  logic        clk,
	input  logic        en,
	input  logic        q20,
	input  logic [27:0] angle,
	output logic [30:0] bam
);
	import hca_pkg::*;

	logic [56:0] prod1_s1;
	logic [27:0] a_s1;
	logic [22:0] q0_s2;
	logic [5:0]  r_s2;
	logic [22:0] q0_s3;
	logic [32:0] prod2_s3;
	logic [30:0] bam_s4;

	logic [22:0] q0_est;
	logic [28:0] r_est;
	logic [15:0] v;
	logic [31:0] hi;

	always_comb begin
		q0_est = prod1_s1[56:RECIP45_WIDE_SH];
		r_est  = {1'b0, a_s1} - 29'(29'(q0_est) * DIV_BY);
		v  = q20 ? 16'({r_s2, 9'b0}) + ROUND_BIAS : 16'({r_s2, 8'b0}) + ROUND_BIAS;
		hi = q20 ? 32'({q0_s3, 9'b0}) : 32'({q0_s3, 8'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod1_s1 <= 57'(angle * RECIP45_WIDE);
			a_s1     <= angle;
			// guard step, the estimate is never more than one short
			if (r_est >= DIV_BY) begin
				q0_s2 <= q0_est + 23'd1;
				r_s2  <= 6'(r_est - DIV_BY);
			end else begin
				q0_s2 <= q0_est;
				r_s2  <= r_est[5:0];
			end
			q0_s3    <= q0_s2;
			prod2_s3 <= 33'(v * RECIP45_NARROW);
			bam_s4   <= 31'(hi + 32'(prod2_s3[32:RECIP45_NARROW_SH]));
		end
	end

	assign bam = bam_s4;

endmodule

FILE: design/hca_cordic_cell.sv
// one rotation step of the cordic chain
module hca_cordic_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hca_pkg::STEP_W-1:0]    step,
	input  hca_pkg::lane_t                lane_in,
	output hca_pkg::lane_t                lane_out
);
	import hca_pkg::*;

	lane_t lane_q;
	lane_t nxt;
	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;
	logic signed [VEC_W-1:0] t;

	always_comb begin
		dx = lane_in.y >>> step;
		dy = lane_in.x >>> step;
		t  = VEC_W'(signed'({2'b00, atan_bam(step)}));
		if (!lane_in.z[VEC_W-1]) begin
			nxt.x = lane_in.x - dx;
			nxt.y = lane_in.y + dy;
			nxt.z = lane_in.z - t;
		end else begin
			nxt.x = lane_in.x + dx;
			nxt.y = lane_in.y - dy;
			nxt.z = lane_in.z + t;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
		end
	end

	assign lane_out = lane_q;

endmodule

FILE: design/hca_combine.sv
// squares, cosine product and saturating sum, last stage is the output register
module hca_combine (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [hca_pkg::VEC_W-1:0] sin_lat,
	input  logic signed [hca_pkg::VEC_W-1:0] sin_lon,
	input  logic signed [hca_pkg::VEC_W-1:0] cos_a,
	input  logic signed [hca_pkg::VEC_W-1:0] cos_b,
	input  logic                            neg,
	output logic [hca_pkg::OUT_W-1:0]        hav
);
	import hca_pkg::*;

	function automatic logic [30:0] clamp_unit(input logic signed [VEC_W-1:0] v);
		logic [30:0] r;
		if (v[VEC_W-1])
			r = 31'd0;
		else if (v > signed'(VEC_W'(ONE_Q30)))
			r = ONE_Q30;
		else
			r = v[30:0];
		return r;
	endfunction

	logic [61:0] slat_sq_s1, slon_sq_s1, cprod_s1;
	logic        neg_s1, neg_s2, neg_s3;
	logic [32:0] hlat_s2, hlon_s2, hlat_s3;
	logic [30:0] prod_s2;
	logic [63:0] tm_s3;
	logic [31:0] hav_s4;

	logic [30:0] sl, so, ca, cb;
	logic [32:0] term;
	logic signed [34:0] sum;

	always_comb begin
		sl = clamp_unit(sin_lat);
		so = clamp_unit(sin_lon);
		ca = clamp_unit(cos_a);
		cb = clamp_unit(cos_b);
		term = 33'((65'(tm_s3) + 65'h2000_0000) >> 30);
		if (neg_s3)
			sum = signed'({2'b00, hlat_s3}) - signed'({2'b00, term});
		else
			sum = signed'({2'b00, hlat_s3}) + signed'({2'b00, term});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slat_sq_s1 <= 62'(sl * sl);
			slon_sq_s1 <= 62'(so * so);
			cprod_s1   <= 62'(ca * cb);
			neg_s1     <= neg;
			hlat_s2 <= 33'((63'(slat_sq_s1) + 63'h800_0000) >> 28);
			hlon_s2 <= 33'((63'(slon_sq_s1) + 63'h800_0000) >> 28);
			prod_s2 <= 31'((63'(cprod_s1) + 63'h2000_0000) >> 30);
			neg_s2  <= neg_s1;
			tm_s3   <= 64'(prod_s2 * hlon_s2);
			hlat_s3 <= hlat_s2;
			neg_s3  <= neg_s2;
			if (sum[34])
				hav_s4 <= '0;
			else if (sum[33:32] != 2'b00)
				hav_s4 <= '1;
			else
				hav_s4 <= sum[31:0];
		end
	end

	assign hav = hav_s4;

endmodule

FILE: tb/haversine_central_angle_test.sv
// self-checking testbench for the haversine central angle block
module haversine_central_angle_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hca_pkg::*;

	localparam longint LAT_SPAN = 94371840;
	localparam longint LON_SPAN = 188743680;
	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
	} point_t;

	localparam logic [31:0] ARCTAN_TURN [0:30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	hca_point_if pt();
	hca_result_if res();

	haversine_central_angle dut (
		.clk(clk), .arst_n(arst_n), .point(pt.sink), .result(res.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	point_t pend[$];
	logic [OUT_W-1:0] hav_expected[$];
	longint query_lat_q, query_lon_q;
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0, gap_left = 0;
	int stall_mode = 0, stall_age = 0;

	// rotation-mode cordic, cos and sin in q.30 clamped to [0, 1]
	function automatic void rotate(input longint angle, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = angle;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ARCTAN_TURN[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ARCTAN_TURN[i]);
			end
		end
		c = x < 0 ? 0 : (x > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : x);
		s = y < 0 ? 0 : (y > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : y);
	endfunction

	// sin^2 of half the difference, q.32; the q.20 difference is the q.21 half angle
	function automatic longint unsigned half_sin_sq(input longint d);
		longint unsigned a;
		longint c, s;
		a = d < 0 ? -d : d;
		a = a % 377487360;
		if (a > 188743680)
			a = 377487360 - a;
		rotate((a * 256 + 22) / 45, c, s);
		return (longint'(s) * longint'(s) + (64'd1 << 27)) >> 28;
	endfunction

	function automatic longint cos_lat(input longint lat);
		longint unsigned a;
		longint c, s;
		bit neg;
		a = lat < 0 ? -lat : lat;
		neg = 0;
		a = a % (2 * 188743680);
		if (a > 188743680)
			a = 2 * 188743680 - a;
		if (a > 94371840) begin
			a = 188743680 - a;
			neg = 1;
		end
		rotate((a * 512 + 22) / 45, c, s);
		return neg ? -c : c;
	endfunction

	function automatic logic [OUT_W-1:0] predict_hav(input longint plat, input longint plon);
		longint unsigned hlat, hlon, ma, mb, prod, term;
		longint ca, cb, sum;
		hlat = half_sin_sq(query_lat_q - plat);
		hlon = half_sin_sq(query_lon_q - plon);
		ca = cos_lat(query_lat_q);
		cb = cos_lat(plat);
		ma = ca < 0 ? -ca : ca;
		mb = cb < 0 ? -cb : cb;
		prod = (ma * mb + (64'd1 << 29)) >> 30;
		term = (prod * hlon + (64'd1 << 29)) >> 30;
		sum = ((ca < 0) != (cb < 0)) ? longint'(hlat) - longint'(term)
			: longint'(hlat) + longint'(term);
		if (sum < 0)
			sum = 0;
		if (sum > 64'sh0FFFF_FFFF)
			sum = 64'sh0FFFF_FFFF;
		return sum[OUT_W-1:0];
	endfunction

	// point source: bursts with random gaps, valid held until the transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt.valid <= 1'b0;
		end else begin
			if (pt.valid && pt.ready) begin
				hav_expected.push_back(predict_hav(pt.point_lat, pt.point_lon));
				void'(pend.pop_front());
			end
			if (!pt.valid || pt.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					pt.valid <= 1'b0;
				end else if (pend.size() > 0) begin
					pt.valid <= 1'b1;
					pt.point_lat <= pend[0].lat;
					pt.point_lon <= pend[0].lon;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					pt.valid <= 1'b0;
				end
			end
		end
	end

	// result sink: stall pattern changes every so often
	always @(posedge clk) begin
		if (arst_n) begin
			stall_age++;
			if (stall_age >= 100) begin
				stall_age = 0;
				stall_mode = $urandom_range(0, 2);
			end
			case (stall_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= $urandom_range(0, 1);
				default: res.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (hav_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result hav_angle=%h", res.hav_angle);
			end else begin
				if (res.hav_angle !== hav_expected[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("hav_angle mismatch: expected %h actual %h",
							hav_expected[0], res.hav_angle);
				end
				void'(hav_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((pt.valid && pt.ready) || (res.valid && res.ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_QUERY_LAT)
			query_lat_q = longint'(signed'(val[LAT_W-1:0]));
		else
			query_lon_q = longint'(signed'(val[LON_W-1:0]));
	endtask

	task automatic set_query(input longint lat, input longint lon);
		write_reg(REG_QUERY_LAT, 32'(lat));
		write_reg(REG_QUERY_LON, 32'(lon));
	endtask

	task automatic add_point(input longint lat, input longint lon);
		point_t p;
		p.lat = lat[LAT_W-1:0];
		p.lon = lon[LON_W-1:0];
		pend.push_back(p);
	endtask

	// source waits for every result, then the pipeline is left to empty
	task automatic drain();
		while (pend.size() > 0 || hav_expected.size() > 0)
			@(posedge clk);
		repeat (LAT + 8) @(posedge clk);
	endtask

	function automatic longint rand_lat();
		case ($urandom_range(0, 9))
			0: return longint'(signed'(28'($urandom)));
			1: return query_lat_q + $urandom_range(0, 2000) - 1000;
			default: return longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN;
		endcase
	endfunction

	function automatic longint rand_lon();
		case ($urandom_range(0, 9))
			0: return longint'(signed'(29'($urandom)));
			1: return query_lon_q + $urandom_range(0, 2000) - 1000;
			default: return longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN;
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pt.valid = 1'b0;
		pt.point_lat = '0;
		pt.point_lon = '0;
		res.ready = 1'b0;
		query_lat_q = 0;
		query_lon_q = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset query: same point, antipode, poles, range ends, out-of-range latitudes
		add_point(0, 0);
		add_point(0, LON_SPAN);
		add_point(0, -LON_SPAN);
		add_point(LAT_SPAN, 0);
		add_point(-LAT_SPAN, 0);
		add_point(LAT_SPAN, LON_SPAN);
		add_point(-LAT_SPAN, -LON_SPAN);
		add_point(-(64'sd1 <<< 27), -(64'sd1 <<< 28));
		add_point((64'sd1 <<< 27) - 1, (64'sd1 <<< 28) - 1);
		add_point(-1, -1);
		add_point(1, 1);
		add_point(2 * LAT_SPAN - 1, 0);
		add_point(0, 2 * LON_SPAN);
		drain();

		set_query(LAT_SPAN, LON_SPAN);
		add_point(LAT_SPAN, LON_SPAN);
		add_point(-LAT_SPAN, -LON_SPAN);
		add_point(0, 0);
		add_point((64'sd1 <<< 27) - 1, (64'sd1 <<< 28) - 1);
		drain();

		set_query(-LAT_SPAN, -LON_SPAN);
		add_point(LAT_SPAN, LON_SPAN);
		add_point(-LAT_SPAN, -LON_SPAN);
		add_point(-(64'sd1 <<< 27), -(64'sd1 <<< 28));
		add_point(0, 0);
		drain();

		set_query(-(64'sd1 <<< 27), (64'sd1 <<< 28) - 1);
		add_point(0, LON_SPAN);
		add_point(LAT_SPAN, 0);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph % 4 == 3)
				set_query(longint'(signed'(28'($urandom))), longint'(signed'(29'($urandom))));
			else
				set_query(longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN,
					longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN);
			repeat (125) add_point(rand_lat(), rand_lon());
			drain();
		end

		if (mismatches == 0 && hav_expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
